@@ sv/isl_pkg.sv @@
// ----------------------------------------------------------------------------
// isl_pkg
// Shared types and codes for the indexed stack list: request and status
// codes, the per-cell command kinds and the command word broadcast to cells.
// ----------------------------------------------------------------------------
package isl_pkg;

   localparam int WORD_W    = 32;
   localparam int DEPTH_DEF = 64;

   localparam logic [2:0] REQ_PUSH   = 3'd0;
   localparam logic [2:0] REQ_POP    = 3'd1;
   localparam logic [2:0] REQ_GET    = 3'd2;
   localparam logic [2:0] REQ_SET    = 3'd3;
   localparam logic [2:0] REQ_INSERT = 3'd4;
   localparam logic [2:0] REQ_REMOVE = 3'd5;
   localparam logic [2:0] REQ_CLEAR  = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef enum logic [1:0] {
      CMD_HOLD  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_INS   = 2'd2,
      CMD_DEL   = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [WORD_W-1:0]   word;
   } cell_cmd_type;

endpackage

@@ sv/isl_cell.sv @@
// ----------------------------------------------------------------------------
// isl_cell
// One storage cell of the list. It holds one word and, on each command,
// keeps it, takes the new word, or takes the word of its lower or upper
// neighbor. It also drives its word onto the read bus when addressed.
// ----------------------------------------------------------------------------
module isl_cell
   import isl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   parameter int IDX   = 0,
   localparam int POS_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  cell_cmd_type        cmd,
   input  logic [POS_W-1:0]    wr_index,
   input  logic [POS_W-1:0]    rd_index,
   input  logic [WORD_W-1:0]   lower_word,
   input  logic [WORD_W-1:0]   upper_word,
   output logic [WORD_W-1:0]   word,
   output logic [WORD_W-1:0]   rd_word
);

   localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      unique case (cmd.kind)
         CMD_HOLD: begin
            word_in = word_ff;
         end
         CMD_WRITE: begin
            if (MY_IDX == wr_index) begin
               word_in = cmd.word;
            end
         end
         CMD_INS: begin
            if (MY_IDX == wr_index) begin
               word_in = cmd.word;
            end else if (MY_IDX > wr_index) begin
               word_in = lower_word;
            end
         end
         CMD_DEL: begin
            if (MY_IDX >= wr_index) begin
               word_in = upper_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word    = word_ff;
   assign rd_word = (MY_IDX == rd_index) ? word_ff : '0;

endmodule

@@ sv/indexed_stack_list_core.sv @@
// ----------------------------------------------------------------------------
// indexed_stack_list_core
// Ordered store of up to DEPTH signed words, usable as a stack and as an
// indexed list, built as a row of cells that shift in parallel.
// ----------------------------------------------------------------------------
// Usage: a request beat on the req_ channel carries an operation code
// (push, pop, get, set, insert, remove, clear), a position and a word.
// Each request gives exactly one response beat on the rsp_ channel with the
// returned word, the fill count, an empty flag and a status code.
// The response is registered at the edge that accepts the request.
// Throughput is one request per cycle unless the request channel stalls;
// every cell shifts or writes in that same cycle, so an insert or remove
// costs no more than a push. The read path is an OR of the addressed cell
// words. The request channel stalls only while a response is held and the
// receiver stalls the response channel; the held response stays stable.
// Reset clears the fill count and the response valid flag; stored words
// are not cleared and are read only after they have been written.
// ----------------------------------------------------------------------------
module indexed_stack_list_core
   import isl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   localparam int POS_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_type,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [WORD_W-1:0]  req_word_in,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [WORD_W-1:0]  rsp_word_out,
   output logic [CNT_W-1:0]          rsp_fill_count,
   output logic                      rsp_is_empty,
   output logic [1:0]                rsp_status
);

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic [WORD_W-1:0]   word_out_ff;
   logic [CNT_W-1:0]    fill_ff;
   logic                empty_ff;
   logic [1:0]          status_ff;

   logic                accept;
   logic                full;
   logic                empty;
   logic                in_range;
   logic [POS_W-1:0]    top_index;
   logic [POS_W-1:0]    rd_index;
   logic [POS_W-1:0]    wr_index;
   cmd_kind_type        kind;
   cell_cmd_type        cmd;
   logic [WORD_W-1:0]   rd_word;
   logic [WORD_W-1:0]   word_res;
   logic [1:0]          status_res;

   logic [WORD_W-1:0]   cell_word [DEPTH];
   logic [WORD_W-1:0]   cell_rd   [DEPTH];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign in_range  = (CNT_W'(req_position) < count_ff);
   assign top_index = POS_W'(count_ff - CNT_W'(1));
   assign rd_index  = (req_type == REQ_POP) ? top_index : req_position;

   always_comb begin
      rd_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_word = rd_word | cell_rd[i];
      end
   end

   always_comb begin
      count_in   = count_ff;
      kind       = CMD_HOLD;
      wr_index   = req_position;
      word_res   = '0;
      status_res = ST_OK;
      unique case (req_type)
         REQ_PUSH: begin
            if (full) begin
               status_res = ST_FULL;
            end else begin
               kind     = CMD_WRITE;
               wr_index = POS_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_POP: begin
            if (empty) begin
               status_res = ST_EMPTY;
            end else begin
               word_res = rd_word;
               count_in = count_ff - CNT_W'(1);
            end
         end
         REQ_GET: begin
            if (!in_range) begin
               status_res = ST_RANGE;
            end else begin
               word_res = rd_word;
            end
         end
         REQ_SET: begin
            if (!in_range) begin
               status_res = ST_RANGE;
            end else begin
               kind = CMD_WRITE;
            end
         end
         REQ_INSERT: begin
            if (full) begin
               status_res = ST_FULL;
            end else if (!in_range) begin
               kind     = CMD_WRITE;
               wr_index = POS_W'(count_ff);
               count_in = count_ff + CNT_W'(1);
            end else begin
               kind     = CMD_INS;
               count_in = count_ff + CNT_W'(1);
            end
         end
         REQ_REMOVE: begin
            if (empty) begin
               status_res = ST_EMPTY;
            end else if (!in_range) begin
               status_res = ST_RANGE;
            end else begin
               kind     = CMD_DEL;
               word_res = rd_word;
               count_in = count_ff - CNT_W'(1);
            end
         end
         REQ_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   assign cmd.kind = accept ? kind : CMD_HOLD;
   assign cmd.word = req_word_in;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] lower_word;
      logic [WORD_W-1:0] upper_word;

      if (i == 0) begin : g_first
         assign lower_word = '0;
      end else begin : g_lower
         assign lower_word = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign upper_word = cell_word[i];
      end else begin : g_upper
         assign upper_word = cell_word[i+1];
      end

      isl_cell #(
         .DEPTH (DEPTH),
         .IDX   (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .wr_index   (wr_index),
         .rd_index   (rd_index),
         .lower_word (lower_word),
         .upper_word (upper_word),
         .word       (cell_word[i]),
         .rd_word    (cell_rd[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         word_out_ff <= word_res;
         fill_ff     <= count_in;
         empty_ff    <= (count_in == '0);
         status_ff   <= status_res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_out   = word_out_ff;
   assign rsp_fill_count = fill_ff;
   assign rsp_is_empty   = empty_ff;
   assign rsp_status     = status_ff;

endmodule
